### rtl/swmm_pkg.sv
// Shared types and constants of the sliding window min/max scanner.
package swmm_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int POS_W       = 32;
  localparam int WSIZE_W     = 11;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_THRESHOLD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_THRESHOLD = 2'd2;

  localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RESET = 11'd16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start_of_track;
  } in_word_t;

  typedef struct packed {
    logic        [POS_W-1:0]    position;
    logic signed [SAMPLE_W-1:0] window_min;
    logic signed [SAMPLE_W-1:0] window_max;
  } out_word_t;

endpackage

### rtl/swmm_ram.sv
// Generic single-port synchronous RAM with a registered read.
module swmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### rtl/sliding_window_minmax_scan.sv
// Top level of the sliding window min/max scanner with its queue sequencer.
//
//   channel   direction   handshake             payload
//   in        input       in_valid / in_ready   in_word   (sample, start_of_track)
//   out       output      out_valid / out_ready out_word  (position, window_min, window_max)
//   cfg       input       cfg_en                cfg_index, cfg_data
//
// One word is worked on at a time; in_ready is high only between words. Each word walks
// a min queue and then a max queue that share one single-port RAM, popping entries from a
// queue's back and skipping entries at its front. After window_size is written, the first
// word may skip up to WINDOW_DEPTH - 1 entries per queue.
// Reset is synchronous and leaves both queues empty; no memory clearing is needed.
// A finished result waits in the output register while the next word is taken; a word
// whose result finds that register still full waits until the held result is taken.
module sliding_window_minmax_scan #(
  parameter int WINDOW_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  swmm_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output swmm_pkg::out_word_t                 out_word,
  input  logic                                cfg_en,
  input  logic [swmm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [swmm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import swmm_pkg::*;

  // Queue pointers carry one wrap bit above the ring index; stamps use the same width.
  localparam int PW      = $clog2(WINDOW_DEPTH) + 1;
  localparam int EW      = (PW > WSIZE_W) ? PW : WSIZE_W;
  localparam int ENTRY_W = SAMPLE_W + PW;
  localparam int RAM_D   = 2 ** PW;
  localparam logic [EW-1:0]    DEPTH_E   = EW'(WINDOW_DEPTH);
  localparam logic [POS_W-1:0] COUNT_MAX = {POS_W{1'b1}};

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_HEAD_RD   = 4'd1;
  localparam logic [3:0] S_HEAD_CHK  = 4'd2;
  localparam logic [3:0] S_BACK_RD   = 4'd3;
  localparam logic [3:0] S_BACK_CHK  = 4'd4;
  localparam logic [3:0] S_PUSH      = 4'd5;
  localparam logic [3:0] S_FRONT_RD  = 4'd6;
  localparam logic [3:0] S_FRONT_CHK = 4'd7;
  localparam logic [3:0] S_DONE      = 4'd8;

  logic [3:0]                 state;
  logic                       phase;
  logic signed [SAMPLE_W-1:0] samp;
  logic [POS_W-1:0]           count;
  logic [PW-1:0]              stamp;
  logic [PW-1:0]              head [2];
  logic [PW-1:0]              scan [2];
  logic [PW-1:0]              tail [2];
  logic signed [SAMPLE_W-1:0] ext [2];
  logic [WSIZE_W-1:0]         window_size;
  logic signed [SAMPLE_W-1:0] min_thr;
  logic signed [SAMPLE_W-1:0] max_thr;

  logic                       ram_en;
  logic                       ram_we;
  logic [PW-1:0]              ram_ptr;
  logic [PW-1:0]              ram_addr;
  logic [ENTRY_W-1:0]         ram_wdata;
  logic [ENTRY_W-1:0]         ram_rdata;

  logic signed [SAMPLE_W-1:0] key;
  logic signed [SAMPLE_W-1:0] rd_key;
  logic [PW-1:0]              age;
  logic [EW-1:0]              ws_e;
  logic [EW-1:0]              w_eff;
  logic [PW-1:0]              h;
  logic [PW-1:0]              s;
  logic [PW-1:0]              t;
  logic                       hit;

  // The max queue runs the same min logic on inverted keys; ~x reverses signed order.
  assign key    = phase ? ~samp : samp;
  assign rd_key = ram_rdata[ENTRY_W-1 -: SAMPLE_W];
  assign age    = stamp - ram_rdata[PW-1:0];
  assign h      = head[phase];
  assign s      = scan[phase];
  assign t      = tail[phase];

  assign ws_e  = EW'(window_size);
  assign w_eff = (ws_e == '0) ? EW'(1) : ((ws_e > DEPTH_E) ? DEPTH_E : ws_e);

  assign hit = (count >= POS_W'(w_eff)) && (ext[0] <= min_thr) && (~ext[1] >= max_thr);

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_ptr   = h;
    ram_wdata = {key, stamp};
    unique case (state)
      S_HEAD_RD: begin
        ram_en  = (h != t);
        ram_ptr = h;
      end
      S_BACK_RD: begin
        ram_en  = (h != t);
        ram_ptr = t - PW'(1);
      end
      S_PUSH: begin
        ram_en  = 1'b1;
        ram_we  = 1'b1;
        ram_ptr = t;
      end
      S_FRONT_RD: begin
        ram_en  = 1'b1;
        ram_ptr = s;
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
    ram_addr = {phase, ram_ptr[PW-2:0]};
  end

  swmm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_D)
  ) u_queue_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= 1'b0;
      count       <= '0;
      stamp       <= '0;
      head[0]     <= '0;
      head[1]     <= '0;
      scan[0]     <= '0;
      scan[1]     <= '0;
      tail[0]     <= '0;
      tail[1]     <= '0;
      out_valid   <= 1'b0;
      window_size <= WINDOW_SIZE_RESET;
      min_thr     <= '0;
      max_thr     <= '0;
    end else begin
      // A result finishing at the same edge refills the register itself.
      if (out_valid && out_ready && !(state == S_DONE && hit)) begin
        out_valid <= 1'b0;
      end

      if (cfg_en) begin
        unique case (cfg_index)
          CFG_WINDOW_SIZE: begin
            window_size <= cfg_data[WSIZE_W-1:0];
            // A new window length may need entries the front scan already passed.
            // A start of track taken at the same edge clears the scan pointers itself.
            if (!(in_ready && in_valid && in_word.start_of_track)) begin
              scan[0] <= head[0];
              scan[1] <= head[1];
            end
          end
          CFG_MIN_THRESHOLD: begin
            min_thr <= cfg_data[SAMPLE_W-1:0];
          end
          CFG_MAX_THRESHOLD: begin
            max_thr <= cfg_data[SAMPLE_W-1:0];
          end
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            samp  <= in_word.sample;
            stamp <= stamp + PW'(1);
            phase <= 1'b0;
            if (in_word.start_of_track) begin
              count   <= POS_W'(1);
              head[0] <= '0;
              head[1] <= '0;
              scan[0] <= '0;
              scan[1] <= '0;
              tail[0] <= '0;
              tail[1] <= '0;
            end else if (count != COUNT_MAX) begin
              count <= count + POS_W'(1);
            end
            state <= S_HEAD_RD;
          end
        end
        S_HEAD_RD: begin
          state <= (h == t) ? S_PUSH : S_HEAD_CHK;
        end
        S_HEAD_CHK: begin
          // Entries at least WINDOW_DEPTH words old can never be needed again.
          if (EW'(age) >= DEPTH_E) begin
            head[phase] <= h + PW'(1);
            if (s == h) begin
              scan[phase] <= h + PW'(1);
            end
          end
          state <= S_BACK_RD;
        end
        S_BACK_RD: begin
          state <= (h == t) ? S_PUSH : S_BACK_CHK;
        end
        S_BACK_CHK: begin
          if (rd_key >= key) begin
            tail[phase] <= t - PW'(1);
            if (s == t) begin
              scan[phase] <= t - PW'(1);
            end
            state <= S_BACK_RD;
          end else begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          tail[phase] <= t + PW'(1);
          state       <= S_FRONT_RD;
        end
        S_FRONT_RD: begin
          state <= S_FRONT_CHK;
        end
        S_FRONT_CHK: begin
          if (EW'(age) >= w_eff) begin
            scan[phase] <= s + PW'(1);
            state       <= S_FRONT_RD;
          end else begin
            ext[phase] <= rd_key;
            if (!phase) begin
              phase <= 1'b1;
              state <= S_HEAD_RD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!hit) begin
            state <= S_IDLE;
          end else if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_word.position   <= count - POS_W'(w_eff);
            out_word.window_min <= ext[0];
            out_word.window_max <= ~ext[1];
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The front scan pointer always lies between head and tail of its queue.
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (PW'(scan[0] - head[0]) <= PW'(tail[0] - head[0])) &&
    (PW'(scan[1] - head[1]) <= PW'(tail[1] - head[1])))
    else $error("front scan pointer outside its queue");

  // A queue never holds more entries than the window store can age out.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (EW'(PW'(tail[0] - head[0])) <= DEPTH_E) && (EW'(PW'(tail[1] - head[1])) <= DEPTH_E))
    else $error("queue holds more than WINDOW_DEPTH entries");

  // The newest entry always lies inside the window, so the scan never runs off the end.
  a_scan_stops: assert property (@(posedge clk) disable iff (rst)
    (state == S_FRONT_CHK) |-> (scan[phase] != tail[phase]))
    else $error("front scan reached the queue tail");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (out_word.window_min <= out_word.window_max))
    else $error("window minimum above window maximum");

endmodule

### bench/swmm_checker.sv
// Checker for the sliding window min/max scanner: predicts window results and compares them.
module swmm_checker #(
  parameter int WINDOW_DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  swmm_pkg::in_word_t               in_word,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  swmm_pkg::out_word_t              out_word,
  input  logic                             cfg_en,
  input  logic [swmm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [swmm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               mismatches,
  output int                               pending,
  output int                               results_seen
);
  import swmm_pkg::*;

  logic signed [SAMPLE_W-1:0] track_ring [WINDOW_DEPTH];
  int unsigned                ring_wr;
  logic [POS_W-1:0]           track_len;
  logic [WSIZE_W-1:0]         win_reg;
  logic signed [SAMPLE_W-1:0] min_thr;
  logic signed [SAMPLE_W-1:0] max_thr;
  out_word_t                  expected_windows [$];

  task automatic take_sample(input in_word_t w);
    int unsigned span;
    int unsigned idx;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    out_word_t hit;
    if (w.start_of_track) begin
      ring_wr = 0;
      track_len = '0;
    end
    track_ring[ring_wr] = w.sample;
    idx = ring_wr;
    ring_wr = (ring_wr + 1) % WINDOW_DEPTH;
    if (track_len != '1) track_len = track_len + 1;
    // A size of zero behaves as one; sizes beyond the ring are clipped to its depth.
    span = (win_reg == 0) ? 1 : ((win_reg > WINDOW_DEPTH) ? WINDOW_DEPTH : win_reg);
    if (track_len >= span) begin
      lo = track_ring[idx];
      hi = lo;
      for (int k = 1; k < span; k++) begin
        idx = (idx == 0) ? WINDOW_DEPTH - 1 : idx - 1;
        if (track_ring[idx] < lo) lo = track_ring[idx];
        if (track_ring[idx] > hi) hi = track_ring[idx];
      end
      if (lo <= min_thr && hi >= max_thr) begin
        hit.position   = track_len - span;
        hit.window_min = lo;
        hit.window_max = hi;
        expected_windows.push_back(hit);
      end
    end
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    results_seen++;
    if (expected_windows.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result word: position %0d min %0d max %0d",
                 got.position, got.window_min, got.window_max);
    end else begin
      want = expected_windows.pop_front();
      if (got.position !== want.position || got.window_min !== want.window_min ||
          got.window_max !== want.window_max) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d differs: position %0d/%0d min %0d/%0d max %0d/%0d (exp/got)",
                   results_seen, want.position, got.position, want.window_min,
                   got.window_min, want.window_max, got.window_max);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ring_wr = 0;
      track_len = '0;
      win_reg = WINDOW_SIZE_RESET;
      min_thr = '0;
      max_thr = '0;
      expected_windows.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      // Results always stem from earlier words, so compare before predicting this edge's word.
      if (out_valid && out_ready) check_result(out_word);
      if (cfg_en) begin
        case (cfg_index)
          CFG_WINDOW_SIZE:   win_reg = cfg_data[WSIZE_W-1:0];
          CFG_MIN_THRESHOLD: min_thr = cfg_data;
          CFG_MAX_THRESHOLD: max_thr = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_sample(in_word);
    end
    pending = expected_windows.size();
  end

endmodule

### bench/sliding_window_minmax_scan_tb.sv
// Testbench top for the sliding window min/max scanner: stimulus, flow control and verdict.
module sliding_window_minmax_scan_tb;
  import swmm_pkg::*;

  localparam int WINDOW_DEPTH    = 1024;
  localparam int LATENCY_SETTLE  = 6000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_word_t               in_word;
  logic                   out_valid;
  logic                   out_ready;
  out_word_t              out_word;
  logic                   cfg_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatches;
  int pending;
  int results_seen;

  bit quiet;
  bit hold_request;
  int words_sent;
  int settings_used;
  int since_start;
  int longest_track;
  logic signed [SAMPLE_W-1:0] cur_min_thr;
  logic signed [SAMPLE_W-1:0] cur_max_thr;
  logic [WSIZE_W-1:0] big_windows [4] = '{11'd1023, 11'd1024, 11'd2047, 11'd1025};

  sliding_window_minmax_scan #(.WINDOW_DEPTH(WINDOW_DEPTH)) i_dut (.*);

  swmm_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("run timed out with %0d results still expected", pending);
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off requested by the stimulus.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 11);
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return SAMPLE_MIN;
    if (r < 12) return SAMPLE_MAX;
    if (r < 18) return cur_min_thr;
    if (r < 24) return cur_max_thr;
    if (r < 40) return $signed($urandom_range(64)) - 32;
    return $signed($urandom);
  endfunction

  function automatic logic [WSIZE_W-1:0] small_window();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 70) return WSIZE_W'($urandom_range(8, 1));
    return WSIZE_W'($urandom_range(64, 9));
  endfunction

  task automatic send_word(input logic signed [SAMPLE_W-1:0] value, input logic sot);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_word  <= '{sample: value, start_of_track: sot};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    since_start = sot ? 1 : since_start + 1;
    if (since_start > longest_track) longest_track = since_start;
  endtask

  task automatic run_items(input int count, input int start_odds);
    for (int i = 0; i < count; i++)
      send_word(pick_sample(), start_odds > 0 && $urandom_range(start_odds - 1) == 0);
  endtask

  // Wait until every expected result is out and the last word has surely finished.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_en    <= 1'b0;
  endtask

  task automatic apply_settings(input logic [WSIZE_W-1:0] w,
                                input logic signed [SAMPLE_W-1:0] lo,
                                input logic signed [SAMPLE_W-1:0] hi);
    logic [CFG_DATA_W-1:0] size_data;
    // Bits above the size field are don't-care, so fill them with noise.
    size_data = $urandom;
    size_data[WSIZE_W-1:0] = w;
    drain();
    write_reg(CFG_WINDOW_SIZE, size_data);
    write_reg(CFG_MIN_THRESHOLD, lo);
    write_reg(CFG_MAX_THRESHOLD, hi);
    cur_min_thr = lo;
    cur_max_thr = hi;
    settings_used++;
  endtask

  task automatic random_setting(input logic [WSIZE_W-1:0] w);
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    case ($urandom_range(4))
      0: begin lo = SAMPLE_MAX; hi = SAMPLE_MIN; end
      1: begin lo = '0; hi = '0; end
      2: begin lo = SAMPLE_MIN; hi = SAMPLE_MAX; end
      3: begin lo = -$signed($urandom_range(1 << 20)); hi = $urandom_range(1 << 20); end
      default: begin lo = $signed($urandom); hi = $signed($urandom); end
    endcase
    apply_settings(w, lo, hi);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    cfg_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    hold_request = 1'b0;
    cur_min_thr = '0;
    cur_max_thr = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: a window of sixteen, both thresholds zero.
    send_word(SAMPLE_MIN, 1'b1);
    send_word(SAMPLE_MAX, 1'b0);
    send_word('0, 1'b0);
    send_word(-1, 1'b0);
    for (int i = 0; i < 13; i++) send_word(i * 1000 - 6000, 1'b0);

    // A size of zero acts as one; with these thresholds every window matches.
    apply_settings('0, SAMPLE_MAX, SAMPLE_MIN);
    send_word(SAMPLE_MAX, 1'b1);
    send_word(SAMPLE_MIN, 1'b0);
    send_word('0, 1'b0);
    send_word(1, 1'b1);

    // Extremes exactly equal to the thresholds.
    apply_settings(11'd2, -1, 1);
    send_word(-1, 1'b1);
    send_word(1, 1'b0);
    send_word('0, 1'b0);
    send_word(1, 1'b0);

    // Short tracks with frequent restarts.
    for (int p = 0; p < 4; p++) begin
      random_setting(small_window());
      run_items($urandom_range(60, 40), 12);
    end

    // Every word matches while the receiver holds off, so the block backs up.
    apply_settings(11'd1, SAMPLE_MAX, SAMPLE_MIN);
    hold_request = 1'b1;
    run_items(16, 0);

    // One long track, window size changed between stretches of it.
    send_word(pick_sample(), 1'b1);
    for (int p = 0; since_start < 1100; p++) begin
      random_setting(small_window());
      quiet = (p == 3);
      run_items(100, 0);
    end
    quiet = 1'b0;

    // The track is now longer than the ring, so full-depth windows complete at once.
    foreach (big_windows[i]) begin
      random_setting(big_windows[i]);
      run_items(25, 0);
    end

    drain();
    $display("Sent %0d sample words under %0d register settings; %0d window results checked.",
             words_sent, settings_used, results_seen);
    $display("Longest track held %0d samples; window sizes from 0 up to 2047 were used.",
             longest_track);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
